FILE: sv/gcp_pkg.sv
// Shared types, constants and helper functions of the gnomonic camera projection.
package gcp_pkg;

  // Channel and register widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SCALE_W     = 24;
  localparam int MIN_W       = 30;

  // Register indexes (address bit 2)
  localparam logic REG_PLATE_SCALE = 1'b0;
  localparam logic REG_MIN_DENOM   = 1'b1;

  localparam logic [SCALE_W-1:0] PLATE_SCALE_RST = 24'd65536;
  localparam logic [MIN_W-1:0]   MIN_DENOM_RST   = 30'd1074;

  // Angle reduction and phase conversion
  localparam int RED_W = 25;
  localparam int H_W   = 19;
  localparam int F_W   = 13;
  localparam int PH_W  = 32;
  localparam logic signed [26:0] FULL_TURN = 27'sd23592960;
  localparam logic [25:0]        RECIP45   = 26'd47721859;
  localparam logic [RED_W-1:0]   DIV_CONST = 25'd45;
  localparam logic [18:0]        HALF_BIAS = 19'd22;

  // CORDIC datapath
  localparam int CW           = 34;
  localparam int TRIG_W       = 32;
  localparam int CORDIC_DEF   = 24;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Products, denominator and division
  localparam int MUL_W   = 34;
  localparam int DEN_W   = 35;
  localparam int AN_W    = 35;
  localparam int A_W     = 57;
  localparam int D_W     = 59;
  localparam int QUO_W   = 32;
  localparam int LO_W    = 16;
  localparam int OUT_W   = 32;
  localparam logic [21:0] RAD2DEG = 22'd3754936;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [MUL_W-1:0] mval_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;  default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q30 product, rounded half up
  function automatic mval_t mul30(input mval_t a, input mval_t b);
    logic signed [2*MUL_W-1:0] p;
    p = (2*MUL_W)'(a) * (2*MUL_W)'(b) + (2*MUL_W)'(64'sd536870912);
    return MUL_W'(p >>> 30);
  endfunction

endpackage

FILE: sv/gnomonic_camera_projection.sv
// Pipelined gnomonic projection of a source onto the camera plane at a pointing center.
//
//  channel | dir | handshake                      | content
//  in_     | in  | in_tvalid / in_tready          | center and source el/az
//  out_    | out | out_tvalid / out_tready        | cam_x, cam_y, denom_clamped, saturated
//  cfg_    | in  | APB psel/penable/pwrite/pready | plate_scale, min_denominator
//
// One transaction per cycle while the output is not stalled; the pipeline holds one register
// per CORDIC micro-rotation and one per quotient bit of the divider.
// rst_n is synchronous and clears valid bits and configuration registers.
// A stalled output freezes the whole pipeline; the first stage still takes a
// transaction while it is empty, so one input is accepted while a result waits.
module gnomonic_camera_projection
  import gcp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [23:0] centre_elevation, [48:24] centre_azimuth, [72:49] source_elevation,
  // [97:73] source_azimuth, [103:98] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] cam_x, [63:32] cam_y, [64] denom_clamped, [65] saturated, [71:66] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // Stage positions in the valid chain
  localparam int K_RED  = 0;
  localparam int K_COR  = 4;
  localparam int K_QM   = K_COR + CORDIC_ITERATIONS;
  localparam int K_DEN  = K_QM + 3;
  localparam int K_DIV  = K_QM + 6;
  localparam int K_OUT  = K_DIV + QUO_W;
  localparam int NST    = K_OUT + 1;

  logic [NST-1:0] vld_r;
  logic           en;
  logic           ld0;

  logic [SCALE_W-1:0] plate_r;
  logic [MIN_W-1:0]   mind_r;
  logic               cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plate_r <= PLATE_SCALE_RST;
      mind_r  <= MIN_DENOM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PLATE_SCALE: plate_r <= cfg_pwdata[SCALE_W-1:0];
        REG_MIN_DENOM:   mind_r  <= cfg_pwdata[MIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PLATE_SCALE: cfg_prdata = CFG_DATA_W'(plate_r);
      REG_MIN_DENOM:   cfg_prdata = CFG_DATA_W'(mind_r);
    endcase
  end

  // Pipeline advance: whole pipe moves unless the output is stalled
  assign en        = !vld_r[NST-1] || out_tready;
  assign ld0       = en || !vld_r[K_RED];
  assign in_tready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld0) vld_r[K_RED] <= in_tvalid;
      if (en)  vld_r[NST-1:1] <= vld_r[NST-2:0];
    end
  end

  // Reduce the three angles to one turn: center el, source el, az difference
  logic [RED_W-1:0] red_r [3];
  logic [RED_W-1:0] red_nxt [3];

  always_comb begin
    logic signed [26:0] t0, t1, t2;
    t0 = 27'(signed'(in_tdata[23:0]));
    t1 = 27'(signed'(in_tdata[72:49]));
    t2 = signed'({2'b00, in_tdata[97:73]}) - signed'({2'b00, in_tdata[48:24]});
    if (t0 < 0) t0 = t0 + FULL_TURN;
    if (t1 < 0) t1 = t1 + FULL_TURN;
    if (t2 < -FULL_TURN) t2 = t2 + FULL_TURN + FULL_TURN;
    else if (t2 < 0) t2 = t2 + FULL_TURN;
    else if (t2 >= FULL_TURN) t2 = t2 - FULL_TURN;
    red_nxt[0] = RED_W'(t0);
    red_nxt[1] = RED_W'(t1);
    red_nxt[2] = RED_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (ld0) red_r <= red_nxt;
  end

  // Phase = floor((a*8192 + 22) / 45): quotient by 45 first, then the remainder part
  logic [H_W-1:0]   h_r [3];
  logic [RED_W-1:0] redh_r [3];
  logic [H_W-1:0]   hf_r [3];
  logic [F_W-1:0]   f_r [3];
  logic [H_W-1:0]   h_nxt [3];
  logic [F_W-1:0]   f_nxt [3];

  always_comb begin
    logic [50:0] hp;
    logic [5:0]  rem6;
    logic [18:0] tv;
    logic [44:0] fp;
    for (int l = 0; l < 3; l++) begin
      hp       = 51'(red_r[l]) * 51'(RECIP45);
      h_nxt[l] = hp[49:31];
      rem6     = 6'(redh_r[l] - RED_W'(h_r[l]) * DIV_CONST);
      tv       = {rem6, 13'b0} + HALF_BIAS;
      fp       = 45'(tv) * 45'(RECIP45);
      f_nxt[l] = fp[43:31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_nxt;
      redh_r <= red_r;
      hf_r   <= h_r;
      f_r    <= f_nxt;
    end
  end

  // Quadrant fold of the phase into CORDIC start angle
  cval_t     zph_r [3];
  logic [1:0] qph_r [3];
  cval_t     zph_nxt [3];
  logic [1:0] qph_nxt [3];

  always_comb begin
    logic [PH_W-1:0] ph, ps, rr;
    for (int l = 0; l < 3; l++) begin
      ph         = {hf_r[l], 13'b0} + PH_W'(f_r[l]);
      ps         = ph + 32'h2000_0000;
      qph_nxt[l] = ps[31:30];
      rr         = ph - {ps[31:30], 30'b0};
      zph_nxt[l] = CW'(signed'(rr));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zph_r <= zph_nxt;
      qph_r <= qph_nxt;
    end
  end

  // CORDIC rotation, one micro-rotation per stage
  cval_t      cx_r [CORDIC_ITERATIONS][3];
  cval_t      cy_r [CORDIC_ITERATIONS][3];
  cval_t      cz_r [CORDIC_ITERATIONS][3];
  logic [1:0] cq_r [CORDIC_ITERATIONS][3];
  cval_t      cx_nxt [CORDIC_ITERATIONS][3];
  cval_t      cy_nxt [CORDIC_ITERATIONS][3];
  cval_t      cz_nxt [CORDIC_ITERATIONS][3];
  logic [1:0] cq_nxt [CORDIC_ITERATIONS][3];

  always_comb begin
    cval_t xi, yi, zi, dx, dy, at;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      for (int l = 0; l < 3; l++) begin
        if (i == 0) begin
          xi = CORDIC_GAIN;
          yi = '0;
          zi = zph_r[l];
          cq_nxt[i][l] = qph_r[l];
        end else begin
          xi = cx_r[i-1][l];
          yi = cy_r[i-1][l];
          zi = cz_r[i-1][l];
          cq_nxt[i][l] = cq_r[i-1][l];
        end
        dx = yi >>> i;
        dy = xi >>> i;
        at = CW'(atan_turn(5'(i)));
        if (zi >= 0) begin
          cx_nxt[i][l] = xi - dx;
          cy_nxt[i][l] = yi + dy;
          cz_nxt[i][l] = zi - at;
        end else begin
          cx_nxt[i][l] = xi + dx;
          cy_nxt[i][l] = yi - dy;
          cz_nxt[i][l] = zi + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      cq_r <= cq_nxt;
    end
  end

  // Map quadrant back: cos and sin per lane
  logic signed [TRIG_W-1:0] cos_r [3];
  logic signed [TRIG_W-1:0] sin_r [3];
  logic signed [TRIG_W-1:0] cos_nxt [3];
  logic signed [TRIG_W-1:0] sin_nxt [3];

  always_comb begin
    cval_t xf, yf;
    for (int l = 0; l < 3; l++) begin
      xf = cx_r[CORDIC_ITERATIONS-1][l];
      yf = cy_r[CORDIC_ITERATIONS-1][l];
      case (cq_r[CORDIC_ITERATIONS-1][l])
        2'd1:    begin cos_nxt[l] = TRIG_W'(-yf); sin_nxt[l] = TRIG_W'(xf);  end
        2'd2:    begin cos_nxt[l] = TRIG_W'(-xf); sin_nxt[l] = TRIG_W'(-yf); end
        2'd3:    begin cos_nxt[l] = TRIG_W'(yf);  sin_nxt[l] = TRIG_W'(-xf); end
        default: begin cos_nxt[l] = TRIG_W'(xf);  sin_nxt[l] = TRIG_W'(yf);  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  // First products (lane 0 center, 1 source, 2 az difference)
  mval_t p_sssc_r, p_cscc_r, p_cssd_r, p_sscc_r, p_cssc_r, p_cd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_sssc_r <= mul30(MUL_W'(sin_r[1]), MUL_W'(sin_r[0]));
      p_cscc_r <= mul30(MUL_W'(cos_r[1]), MUL_W'(cos_r[0]));
      p_cssd_r <= mul30(MUL_W'(cos_r[1]), MUL_W'(sin_r[2]));
      p_sscc_r <= mul30(MUL_W'(sin_r[1]), MUL_W'(cos_r[0]));
      p_cssc_r <= mul30(MUL_W'(cos_r[1]), MUL_W'(sin_r[0]));
      p_cd_r   <= MUL_W'(cos_r[2]);
    end
  end

  // Second products by cos of az difference
  mval_t q_sssc_r, q_cscccd_r, q_cssd_r, q_sscc_r, q_csscd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_sssc_r   <= p_sssc_r;
      q_cscccd_r <= mul30(p_cscc_r, p_cd_r);
      q_cssd_r   <= p_cssd_r;
      q_sscc_r   <= p_sscc_r;
      q_csscd_r  <= mul30(p_cssc_r, p_cd_r);
    end
  end

  // Denominator clamp, signs and magnitudes (lane 0 x, lane 1 y)
  logic [AN_W-1:0] an_r [2];
  logic [AN_W-1:0] ad_r;
  logic            neg_r [2];
  logic            clamp_r;
  logic [AN_W-1:0] an_nxt [2];
  logic [AN_W-1:0] ad_nxt;
  logic            neg_nxt [2];
  logic            clamp_nxt;
  logic signed [DEN_W-1:0] mval;

  assign mval = (mind_r != '0) ? DEN_W'(mind_r) : DEN_W'(1);

  always_comb begin
    logic signed [DEN_W-1:0] den, xn, yn;
    den = DEN_W'(q_sssc_r) + DEN_W'(q_cscccd_r);
    xn  = DEN_W'(q_cssd_r);
    yn  = DEN_W'(q_sscc_r) - DEN_W'(q_csscd_r);
    clamp_nxt = 1'b0;
    if (den >= 0 && den < mval) begin
      den = mval;
      clamp_nxt = 1'b1;
    end else if (den < 0 && den > -mval) begin
      den = -mval;
      clamp_nxt = 1'b1;
    end
    neg_nxt[0] = !((xn < 0) != (den < 0));
    neg_nxt[1] = (yn < 0) != (den < 0);
    an_nxt[0]  = AN_W'((xn < 0) ? -xn : xn);
    an_nxt[1]  = AN_W'((yn < 0) ? -yn : yn);
    ad_nxt     = AN_W'((den < 0) ? -den : den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_r    <= an_nxt;
      ad_r    <= ad_nxt;
      neg_r   <= neg_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  // Scale numerators to degrees and denominator by plate scale
  logic [A_W-1:0] na_r [2];
  logic [D_W-1:0] dd_r;
  logic           neg_m_r [2];
  logic           clamp_m_r;
  logic [SCALE_W-1:0] scale;

  assign scale = (plate_r != '0) ? plate_r : SCALE_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) na_r[l] <= A_W'(an_r[l]) * A_W'(RAD2DEG);
      dd_r      <= D_W'(ad_r) * D_W'(scale);
      neg_m_r   <= neg_r;
      clamp_m_r <= clamp_r;
    end
  end

  // Quotient overflow check and divider setup
  logic [D_W-1:0]  rem0_r [2];
  logic [LO_W-1:0] lo0_r [2];
  logic            ovf0_r [2];
  logic [D_W-1:0]  d0_r;
  logic            neg0_r [2];
  logic            clamp0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem0_r[l] <= D_W'(na_r[l][A_W-1:LO_W]);
        lo0_r[l]  <= na_r[l][LO_W-1:0];
        ovf0_r[l] <= D_W'(na_r[l][A_W-1:LO_W]) >= dd_r;
      end
      d0_r     <= dd_r;
      neg0_r   <= neg_m_r;
      clamp0_r <= clamp_m_r;
    end
  end

  // Restoring divider, one quotient bit per stage
  logic [D_W-1:0]   dv_rem_r [QUO_W][2];
  logic [LO_W-1:0]  dv_lo_r  [QUO_W][2];
  logic [QUO_W-1:0] dv_q_r   [QUO_W][2];
  logic             dv_ovf_r [QUO_W][2];
  logic             dv_neg_r [QUO_W][2];
  logic [D_W-1:0]   dv_d_r   [QUO_W];
  logic             dv_clamp_r [QUO_W];
  logic [D_W-1:0]   dv_rem_nxt [QUO_W][2];
  logic [LO_W-1:0]  dv_lo_nxt  [QUO_W][2];
  logic [QUO_W-1:0] dv_q_nxt   [QUO_W][2];

  always_comb begin
    logic [D_W:0]     rs;
    logic [D_W-1:0]   ri;
    logic [LO_W-1:0]  li;
    logic [QUO_W-1:0] qi;
    logic [D_W-1:0]   di;
    logic             ge;
    for (int j = 0; j < QUO_W; j++) begin
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          ri = rem0_r[l]; li = lo0_r[l]; qi = '0; di = d0_r;
        end else begin
          ri = dv_rem_r[j-1][l]; li = dv_lo_r[j-1][l];
          qi = dv_q_r[j-1][l];   di = dv_d_r[j-1];
        end
        rs = {ri, li[LO_W-1]};
        ge = rs >= {1'b0, di};
        dv_rem_nxt[j][l] = ge ? D_W'(rs - {1'b0, di}) : D_W'(rs);
        dv_lo_nxt[j][l]  = {li[LO_W-2:0], 1'b0};
        dv_q_nxt[j][l]   = {qi[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r <= dv_rem_nxt;
      dv_lo_r  <= dv_lo_nxt;
      dv_q_r   <= dv_q_nxt;
      dv_ovf_r[0]   <= ovf0_r;
      dv_neg_r[0]   <= neg0_r;
      dv_d_r[0]     <= d0_r;
      dv_clamp_r[0] <= clamp0_r;
      for (int j = 1; j < QUO_W; j++) begin
        dv_ovf_r[j]   <= dv_ovf_r[j-1];
        dv_neg_r[j]   <= dv_neg_r[j-1];
        dv_d_r[j]     <= dv_d_r[j-1];
        dv_clamp_r[j] <= dv_clamp_r[j-1];
      end
    end
  end

  // Sign, saturate and register the result
  logic [OUT_TDATA_W-1:0] out_r;
  logic [OUT_TDATA_W-1:0] out_nxt;

  always_comb begin
    logic [QUO_W:0]   qv;
    logic [OUT_W-1:0] val [2];
    logic             sat;
    sat = 1'b0;
    for (int l = 0; l < 2; l++) begin
      qv = dv_ovf_r[QUO_W-1][l] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, dv_q_r[QUO_W-1][l]};
      if (dv_neg_r[QUO_W-1][l]) begin
        if (qv > 33'h0_8000_0000) begin
          sat = 1'b1;
          val[l] = 32'h8000_0000;
        end else begin
          val[l] = OUT_W'(-qv);
        end
      end else begin
        if (qv > 33'h0_7FFF_FFFF) begin
          sat = 1'b1;
          val[l] = 32'h7FFF_FFFF;
        end else begin
          val[l] = qv[OUT_W-1:0];
        end
      end
    end
    out_nxt = {6'b0, sat, dv_clamp_r[QUO_W-1], val[1], val[0]};
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_tdata  = out_r;
  assign out_tvalid = vld_r[NST-1];

`ifndef NO_ASSERTIONS
  // Input is refused only while a result is stalled at the output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input refused without an output stall");

  // A clamped denominator has exactly the configured minimum magnitude
  a_clamp_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[K_DEN] && clamp_r) |-> (ad_r == AN_W'(mval)))
    else $error("clamped denominator differs from minimum");

  // A saturated result has at least one coordinate on a range limit
  a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[65]) |->
      (out_tdata[31:0] == 32'h8000_0000 || out_tdata[31:0] == 32'h7FFF_FFFF ||
       out_tdata[63:32] == 32'h8000_0000 || out_tdata[63:32] == 32'h7FFF_FFFF))
    else $error("saturation flag without a limit value");
`endif

endmodule

FILE: test/gnomonic_camera_projection_checker.sv
`timescale 1ns / 1ps
// Checker for the gnomonic camera projection: predicts each result and compares it.
module gnomonic_camera_projection_checker
  import gcp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic                   cfg_pready,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen,
  output int                     clamps_seen,
  output int                     sats_seen
);

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic               clamped;
    logic               sat;
  } camera_point_t;

  // Arctangent of 2^-i, 2^32 per turn
  bit [31:0] atan_steps [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic [SCALE_W-1:0] scale_reg;
  logic [MIN_W-1:0]   min_den_reg;
  camera_point_t      expected_points [$];

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Rotate the gain vector to the angle; returns cosine and sine in Q30
  function automatic void rotate_angle(input longint ang, output longint c, output longint s);
    longint             a, z, x, y, dx, dy;
    longint unsigned    n;
    bit [31:0]          ph, rr;
    bit [1:0]           quad;
    a = ang % (longint'(360) <<< 16);
    if (a < 0) a += longint'(360) <<< 16;
    n = (longint'(a) << 16) + 180;
    ph = 32'(n / 360);
    quad = 2'(((64'(ph) + 64'h20000000) >> 30) & 3);
    rr = ph - (32'(quad) << 30);
    z = longint'(signed'(rr));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_steps[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_steps[i]);
      end
    end
    case (quad)
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      2'd3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endfunction

  // floor(a * 2^16 / d), capped at 2^33
  function automatic longint unsigned capped_quotient(input longint unsigned a,
                                                      input longint unsigned d);
    longint unsigned q, r;
    q = a / d;
    r = a % d;
    if (q > 64'd8589934592) return 64'd8589934592;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r -= d;
        q++;
      end
      if (q > 64'd8589934592) return 64'd8589934592;
    end
    return q;
  endfunction

  function automatic longint plane_to_camera(input longint num, input longint den,
                                             input longint unsigned scale, input bit flip,
                                             inout bit sat);
    bit              neg;
    longint unsigned an, ad, q;
    neg = (num < 0) != (den < 0);
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = capped_quotient(an * 64'd3754936, ad * scale);
    if (flip) neg = !neg;
    if (neg) begin
      if (q > 64'd2147483648) begin
        sat = 1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic camera_point_t project_source(input logic [IN_TDATA_W-1:0] d);
    longint          el_c, az_c, el_s, az_s, sc, cc, ss, cs, sd, cd, den, xn, yn, m;
    longint unsigned scale;
    bit              clamped, sat;
    camera_point_t   r;
    el_c = longint'(signed'(d[23:0]));
    az_c = longint'(d[48:24]);
    el_s = longint'(signed'(d[72:49]));
    az_s = longint'(d[97:73]);
    clamped = 0;
    sat = 0;
    scale = scale_reg != 0 ? scale_reg : 1;
    rotate_angle(el_c, cc, sc);
    rotate_angle(el_s, cs, ss);
    rotate_angle(az_s - az_c, cd, sd);
    den = q30_mul(ss, sc) + q30_mul(q30_mul(cs, cc), cd);
    m = min_den_reg != 0 ? longint'(min_den_reg) : 1;
    if (den >= 0 && den < m) begin
      den = m;
      clamped = 1;
    end else if (den < 0 && den > -m) begin
      den = -m;
      clamped = 1;
    end
    xn = q30_mul(cs, sd);
    yn = q30_mul(ss, cc) - q30_mul(q30_mul(cs, sc), cd);
    r.cam_x = 32'(plane_to_camera(xn, den, scale, 1, sat));
    r.cam_y = 32'(plane_to_camera(yn, den, scale, 0, sat));
    r.clamped = clamped;
    r.sat = sat;
    return r;
  endfunction

  // Track registers, predict accepted inputs, compare accepted results
  always @(posedge clk) begin
    camera_point_t want;
    if (!rst_n) begin
      scale_reg <= PLATE_SCALE_RST;
      min_den_reg <= MIN_DENOM_RST;
      expected_points.delete();
      pending <= 0;
      fail_count <= 0;
      results_seen <= 0;
      clamps_seen <= 0;
      sats_seen <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_PLATE_SCALE) scale_reg <= cfg_pwdata[SCALE_W-1:0];
        else min_den_reg <= cfg_pwdata[MIN_W-1:0];
      end
      if (in_tvalid && in_tready) expected_points.push_back(project_source(in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_points.size() == 0) begin
          $error("result with no expectation waiting: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          clamps_seen <= clamps_seen + want.clamped;
          sats_seen <= sats_seen + want.sat;
          if (out_tdata[31:0] !== want.cam_x ||
              out_tdata[63:32] !== want.cam_y ||
              out_tdata[64] !== want.clamped ||
              out_tdata[65] !== want.sat) begin
            fail_count <= fail_count + 1;
            if (out_tdata[31:0] !== want.cam_x)
              $error("cam_x expected %0d actual %0d", want.cam_x, signed'(out_tdata[31:0]));
            if (out_tdata[63:32] !== want.cam_y)
              $error("cam_y expected %0d actual %0d", want.cam_y, signed'(out_tdata[63:32]));
            if (out_tdata[64] !== want.clamped)
              $error("denom_clamped expected %0b actual %0b", want.clamped, out_tdata[64]);
            if (out_tdata[65] !== want.sat)
              $error("saturated expected %0b actual %0b", want.sat, out_tdata[65]);
          end
        end
      end
      pending <= expected_points.size();
    end
  end

endmodule

FILE: test/gnomonic_camera_projection_tb.sv
`timescale 1ns / 1ps
// Testbench top for the gnomonic camera projection: stimulus, register phases and verdict.
module gnomonic_camera_projection_tb;
  import gcp_pkg::*;

  localparam int DRAIN_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int EL_MAX = 5898240;
  localparam int AZ_MAX = 23592959;
  localparam int DEG = 65536;

  logic                   clk;
  logic                   rst_n;
  // [23:0] centre_elevation, [48:24] centre_azimuth, [72:49] source_elevation,
  // [97:73] source_azimuth, [103:98] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // [31:0] cam_x, [63:32] cam_y, [64] denom_clamped, [65] saturated, [71:66] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  int                     fail_count, pending, results_seen, clamps_seen, sats_seen;
  int                     items_sent, idle_cycles, stall_left;

  gnomonic_camera_projection dut (.*);

  gnomonic_camera_projection_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Stall the result side: mostly free runs, with short stalls and a few long ones
  always @(posedge clk) begin
    int r;
    r = $urandom_range(99);
    if (stall_left > 0) begin
      out_tready <= 0;
      stall_left <= stall_left - 1;
    end else if (r < 70) begin
      out_tready <= 1;
    end else begin
      out_tready <= 0;
      stall_left <= (r < 97) ? $urandom_range(0, 2) : $urandom_range(9, 39);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // Hold one transaction until accepted, after an optional gap
  task automatic send_item(input logic signed [23:0] cel, input logic [24:0] caz,
                           input logic signed [23:0] sel, input logic [24:0] saz);
    int gap, r;
    r = $urandom_range(99);
    gap = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, saz, sel, caz, cel};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
  endtask

  // Wait out the pipeline before touching registers
  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_el;
    return 24'($signed($urandom_range(2 * EL_MAX)) - EL_MAX);
  endfunction

  // Mostly realistic fields near the centre, some anywhere, a few raw bit patterns
  task automatic send_random(input int count);
    logic signed [23:0] cel, sel;
    logic [24:0]        caz, saz;
    int                 r;
    repeat (count) begin
      r = $urandom_range(99);
      cel = rand_el();
      caz = 25'($urandom_range(AZ_MAX));
      if (r < 60) begin
        sel = cel + 24'($signed($urandom_range(20 * DEG)) - 10 * DEG);
        saz = caz + 25'($signed($urandom_range(20 * DEG)) - 10 * DEG);
        if (sel > EL_MAX || sel < -EL_MAX) sel = cel;
        if (saz > AZ_MAX) saz = caz;
      end else if (r < 95) begin
        sel = rand_el();
        saz = 25'($urandom_range(AZ_MAX));
      end else begin
        cel = 24'($urandom);
        sel = 24'($urandom);
        caz = 25'($urandom);
        saz = 25'($urandom);
      end
      send_item(cel, caz, sel, saz);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, coincident source, denominator zero and negative
    send_item(24'sd0, 25'd0, 24'sd0, 25'd0);
    send_item(24'(EL_MAX), 25'd0, 24'(EL_MAX), 25'd0);
    send_item(24'(-EL_MAX), 25'(AZ_MAX), 24'(-EL_MAX), 25'(AZ_MAX));
    send_item(24'(EL_MAX), 25'd0, 24'(-EL_MAX), 25'(AZ_MAX));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(90 * DEG));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(270 * DEG));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(180 * DEG));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(89 * DEG + 65000));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(90 * DEG + 500));
    send_item(24'sd0, 25'd0, 24'(60 * DEG), 25'(30 * DEG));
    send_item(24'(45 * DEG), 25'(10 * DEG), 24'(44 * DEG), 25'(11 * DEG));
    send_item(24'sd0, 25'(AZ_MAX), 24'sd0, 25'd0);
    send_item(24'sh800000, 25'h1FFFFFF, 24'sh7FFFFF, 25'h1FFFFFF);
    send_random(260);
    drain();

    // Smallest plate scale and minimum: many saturated results
    write_reg(REG_PLATE_SCALE, 32'd1);
    write_reg(REG_MIN_DENOM, 32'd1);
    send_item(24'sd0, 25'd0, 24'sd0, 25'(90 * DEG));
    send_item(24'sd0, 25'd0, 24'sd0, 25'(90 * DEG - 1));
    send_random(280);
    drain();

    // Largest plate scale and minimum: denominator nearly always forced
    write_reg(REG_PLATE_SCALE, 32'd16777215);
    write_reg(REG_MIN_DENOM, 32'd1073741823);
    send_random(280);
    drain();

    // Mid-range settings
    write_reg(REG_PLATE_SCALE, 32'($urandom_range(2000, 200000)));
    write_reg(REG_MIN_DENOM, 32'($urandom_range(100, 1 << 20)));
    send_random(280);
    drain();

    write_reg(REG_PLATE_SCALE, 32'($urandom_range(1, 16777215)));
    write_reg(REG_MIN_DENOM, 32'($urandom_range(1, 1073741823)));
    send_random(280);
    drain();

    $display("Sent %0d items over five register settings; %0d results checked",
             items_sent, results_seen);
    $display("Results with forced denominator: %0d, with saturation: %0d",
             clamps_seen, sats_seen);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/gcp_pkg.sv
sv/gnomonic_camera_projection.sv
test/gnomonic_camera_projection_checker.sv
test/gnomonic_camera_projection_tb.sv
